@@ rtl/r5_pkg.sv @@
// shared types and constants for the raid-5 locate and recover block
// no dependencies; used by r5_div and the top level
package r5_pkg;

  // fixed field widths
  localparam int unsigned TARGET_W    = 20;
  localparam int unsigned OFFSET_W    = 10;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NDISK_W     = 5;
  localparam int unsigned STRIP_W     = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned CNT_W       = 5;

  // shared divider widths
  localparam int unsigned DIVIDEND_W  = TARGET_W;
  localparam int unsigned DIVISOR_W   = STRIP_W;
  localparam int unsigned DIV_CNT_W   = 5;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_UNAVL = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DISKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_OFF  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_STRIP,
    ST_DIV_TURN,
    ST_DIV_GROUP,
    ST_MUL_A,
    ST_MUL_B,
    ST_CHECK,
    ST_RD,
    ST_RD_WAIT,
    ST_XOR_RD,
    ST_XOR_WAIT,
    ST_DONE
  } state_e;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DIVISOR_W-1:0]  rem;
  } div_rsp_t;

endpackage

@@ rtl/r5_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module r5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/r5_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on r5_pkg
module r5_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  r5_pkg::div_req_t req_i,
  output r5_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [r5_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [r5_pkg::DIVIDEND_W-1:0] quot_q, quot_d;
  logic [r5_pkg::DIVISOR_W-1:0]  rem_q, rem_d;
  logic [r5_pkg::DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [r5_pkg::DIVISOR_W:0]    trial;
  logic [r5_pkg::DIVISOR_W:0]    diff;
  logic                          fits;

  // one trial subtract per cycle
  assign trial = {rem_q, quot_q[r5_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? diff[r5_pkg::DIVISOR_W-1:0] : trial[r5_pkg::DIVISOR_W-1:0];
      quot_d = {quot_q[r5_pkg::DIVIDEND_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == r5_pkg::DIV_CNT_W'(r5_pkg::DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/raid5_block_locate_and_recover.sv @@
// raid-5 left-symmetric word locator with single-disk xor recovery
// depends on r5_pkg, r5_div and r5_ram
//
// input channel s_axis: tuser carries the command (load or query), tdata carries
// target, word_offset and word_value. a load whose target and offset lie within the
// store writes one word into the disk store in the cycle it is accepted and gives
// no item back. a query gives one item on m_axis: tuser is the status, tdata the read or rebuilt word.
// a query runs three divisions on the shared restoring divider, two multiply
// steps and a check, then one read (a read step and a wait step) or a recovery
// sweep (a read and a wait step per present disk, a read step alone per absent
// one and a final step); the done step then hands its item to the output register.
// the block takes a new item only when its sequencer is idle; a finished
// result waits in the output register while the next item is already taken.
// if the receiver stalls, a later query holds in its final step until the
// output register is free.
// reset clears the present bits, the present count, the configuration
// (two disks, strips of one block, last offset zero) and both channels.
// the disk store is not cleared; a word is defined once loaded.
// configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
module raid5_block_locate_and_recover #(
  parameter int unsigned MAX_DISKS  = 16,
  parameter int unsigned DISK_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [r5_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [r5_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [19:0] target, [29:20] word_offset, [61:30] word_value, [63:62] zero
  input  logic [r5_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] command
  input  logic        s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_word
  output logic [r5_pkg::WORD_W-1:0] m_axis_tdata_o,
  // [0] status
  output logic        m_axis_tuser_o
);

  localparam int unsigned DW    = $clog2(MAX_DISKS);
  localparam int unsigned OW    = $clog2(DISK_WORDS);
  localparam int unsigned NW    = $clog2(MAX_DISKS + 1);
  localparam int unsigned GN_W  = r5_pkg::TARGET_W + NW;
  localparam int unsigned GNS_W = GN_W + r5_pkg::STRIP_W;
  localparam int unsigned SUM_W = GNS_W + 2;
  localparam int unsigned WS_W  = r5_pkg::STRIP_W + r5_pkg::STRIP_W;

  // configuration registers
  logic [r5_pkg::NDISK_W-1:0]  cfg_num_q;
  logic [r5_pkg::STRIP_W-1:0]  cfg_strip_q;
  logic [r5_pkg::OFFSET_W-1:0] cfg_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_num_q   <= r5_pkg::NDISK_W'(2);
      cfg_strip_q <= r5_pkg::STRIP_W'(1);
      cfg_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        r5_pkg::REG_NUM_DISKS: cfg_num_q   <= cfg_wdata_i[r5_pkg::NDISK_W-1:0];
        r5_pkg::REG_STRIP:     cfg_strip_q <= cfg_wdata_i;
        r5_pkg::REG_LAST_OFF:  cfg_last_q  <= cfg_wdata_i[r5_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped disk count and strip size
  logic [NW-1:0]              n_w;
  logic [r5_pkg::STRIP_W-1:0] s_w;

  always_comb begin
    if (cfg_num_q < r5_pkg::NDISK_W'(2)) begin
      n_w = NW'(2);
    end else if (32'(cfg_num_q) > MAX_DISKS) begin
      n_w = NW'(MAX_DISKS);
    end else begin
      n_w = NW'(cfg_num_q);
    end
    s_w = (cfg_strip_q == '0) ? r5_pkg::STRIP_W'(1) : cfg_strip_q;
  end

  // input fields
  logic                         in_cmd;
  logic [r5_pkg::TARGET_W-1:0]  in_target;
  logic [r5_pkg::OFFSET_W-1:0]  in_offset;
  logic [r5_pkg::WORD_W-1:0]    in_value;
  logic                         in_acc;
  logic                         load_ok;

  assign in_cmd    = s_axis_tuser_i;
  assign in_target = s_axis_tdata_i[19:0];
  assign in_offset = s_axis_tdata_i[29:20];
  assign in_value  = s_axis_tdata_i[61:30];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_ok   = in_acc && (in_cmd == r5_pkg::CMD_LOAD)
                  && (32'(in_target) < MAX_DISKS) && (32'(in_offset) < DISK_WORDS);

  // sequencer and datapath registers
  r5_pkg::state_e              state_q, state_d;
  logic                        started_q, started_d;
  logic [r5_pkg::TARGET_W-1:0] target_q, target_d;
  logic [r5_pkg::TARGET_W-1:0] strip_q, strip_d;
  logic [r5_pkg::STRIP_W-1:0]  inner_q, inner_d;
  logic [r5_pkg::TARGET_W-1:0] turn_q, turn_d;
  logic [DW-1:0]               disk_q, disk_d;
  logic [r5_pkg::TARGET_W-1:0] group_q, group_d;
  logic [r5_pkg::STRIP_W-1:0]  within_q, within_d;
  logic [GN_W-1:0]             gn_q, gn_d;
  logic [WS_W-1:0]             ws_q, ws_d;
  logic [GNS_W-1:0]            gns_q, gns_d;
  logic [OW-1:0]               word_q, word_d;
  logic [NW-1:0]               idx_q, idx_d;
  logic [r5_pkg::WORD_W-1:0]   acc_q, acc_d;
  logic                        m_valid_q, m_valid_d;
  logic                        m_stat_q, m_stat_d;
  logic [r5_pkg::WORD_W-1:0]   m_data_q, m_data_d;
  logic                        res_stat_q, res_stat_d;
  logic [r5_pkg::WORD_W-1:0]   res_data_q, res_data_d;
  logic [MAX_DISKS-1:0]        present_q, present_d;
  logic [r5_pkg::CNT_W-1:0]    pcnt_q, pcnt_d;

  r5_pkg::div_req_t div_req;
  r5_pkg::div_rsp_t div_rsp;

  logic [DW+OW-1:0]            raddr;
  logic [DW+OW-1:0]            waddr;
  logic [r5_pkg::WORD_W-1:0]   rdata;

  logic [SUM_W-1:0]            word_sum;
  logic [r5_pkg::STRIP_W-1:0]  bound;
  logic                        word_ok;
  logic                        out_free;

  assign waddr    = {in_target[DW-1:0], OW'(in_offset)};
  assign out_free = !m_valid_q || m_axis_tready_i;

  // located word offset
  assign bound    = r5_pkg::STRIP_W'(n_w - NW'(1) - NW'(disk_q));
  assign word_sum = SUM_W'(gns_q)
                  + ((within_q >= bound) ? SUM_W'(s_w) : SUM_W'(0))
                  + SUM_W'(ws_q) + SUM_W'(inner_q);
  assign word_ok  = (word_sum <= SUM_W'(cfg_last_q)) && (word_sum < SUM_W'(DISK_WORDS));

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    target_d   = target_q;
    strip_d    = strip_q;
    inner_d    = inner_q;
    turn_d     = turn_q;
    disk_d     = disk_q;
    group_d    = group_q;
    within_d   = within_q;
    gn_d       = gn_q;
    ws_d       = ws_q;
    gns_d      = gns_q;
    word_d     = word_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    res_stat_d = res_stat_q;
    res_data_d = res_data_q;
    present_d  = present_q;
    pcnt_d     = pcnt_q;
    m_valid_d  = m_valid_q;
    m_stat_d   = m_stat_q;
    m_data_d   = m_data_q;
    div_req    = '0;
    raddr      = {disk_q, word_q};

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      r5_pkg::ST_IDLE: begin
        if (load_ok) begin
          if (!present_q[in_target[DW-1:0]]) begin
            present_d[in_target[DW-1:0]] = 1'b1;
            if (pcnt_q != '1) begin
              pcnt_d = pcnt_q + 1'b1;
            end
          end
        end
        if (in_acc && (in_cmd == r5_pkg::CMD_QUERY)) begin
          target_d  = in_target;
          started_d = 1'b0;
          state_d   = r5_pkg::ST_DIV_STRIP;
        end
      end
      r5_pkg::ST_DIV_STRIP: begin
        div_req.dividend = target_q;
        div_req.divisor  = s_w;
        div_req.start    = !started_q;
        started_d        = 1'b1;
        if (div_rsp.done) begin
          strip_d   = div_rsp.quot;
          inner_d   = div_rsp.rem;
          started_d = 1'b0;
          state_d   = r5_pkg::ST_DIV_TURN;
        end
      end
      r5_pkg::ST_DIV_TURN: begin
        div_req.dividend = strip_q;
        div_req.divisor  = r5_pkg::DIVISOR_W'(n_w);
        div_req.start    = !started_q;
        started_d        = 1'b1;
        if (div_rsp.done) begin
          turn_d    = div_rsp.quot;
          disk_d    = div_rsp.rem[DW-1:0];
          started_d = 1'b0;
          state_d   = r5_pkg::ST_DIV_GROUP;
        end
      end
      r5_pkg::ST_DIV_GROUP: begin
        div_req.dividend = turn_q;
        div_req.divisor  = r5_pkg::DIVISOR_W'(n_w - NW'(1));
        div_req.start    = !started_q;
        started_d        = 1'b1;
        if (div_rsp.done) begin
          group_d   = div_rsp.quot;
          within_d  = div_rsp.rem;
          started_d = 1'b0;
          state_d   = r5_pkg::ST_MUL_A;
        end
      end
      r5_pkg::ST_MUL_A: begin
        gn_d    = GN_W'(group_q) * GN_W'(n_w);
        ws_d    = WS_W'(within_q) * WS_W'(s_w);
        state_d = r5_pkg::ST_MUL_B;
      end
      r5_pkg::ST_MUL_B: begin
        gns_d   = GNS_W'(gn_q) * GNS_W'(s_w);
        state_d = r5_pkg::ST_CHECK;
      end
      r5_pkg::ST_CHECK: begin
        word_d     = word_sum[OW-1:0];
        res_stat_d = r5_pkg::STAT_UNAVL;
        res_data_d = '0;
        state_d    = r5_pkg::ST_DONE;
        if (word_ok) begin
          if (present_q[disk_q]) begin
            state_d = r5_pkg::ST_RD;
          end else if ((32'(pcnt_q) + 32'd1) >= 32'(n_w)) begin
            idx_d   = '0;
            acc_d   = '0;
            state_d = r5_pkg::ST_XOR_RD;
          end
        end
      end
      r5_pkg::ST_RD: begin
        raddr   = {disk_q, word_q};
        state_d = r5_pkg::ST_RD_WAIT;
      end
      r5_pkg::ST_RD_WAIT: begin
        res_stat_d = r5_pkg::STAT_OK;
        res_data_d = rdata;
        state_d    = r5_pkg::ST_DONE;
      end
      r5_pkg::ST_XOR_RD: begin
        raddr = {idx_q[DW-1:0], word_q};
        if (idx_q == n_w) begin
          res_stat_d = r5_pkg::STAT_OK;
          res_data_d = acc_q;
          state_d    = r5_pkg::ST_DONE;
        end else if (present_q[idx_q[DW-1:0]]) begin
          state_d = r5_pkg::ST_XOR_WAIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      r5_pkg::ST_XOR_WAIT: begin
        acc_d   = acc_q ^ rdata;
        idx_d   = idx_q + 1'b1;
        state_d = r5_pkg::ST_XOR_RD;
      end
      r5_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_stat_d  = res_stat_q;
          m_data_d  = res_data_q;
          state_d   = r5_pkg::ST_IDLE;
        end
      end
      default: state_d = r5_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= r5_pkg::ST_IDLE;
      started_q <= 1'b0;
      present_q <= '0;
      pcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      present_q <= present_d;
      pcnt_q    <= pcnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    strip_q    <= strip_d;
    inner_q    <= inner_d;
    turn_q     <= turn_d;
    disk_q     <= disk_d;
    group_q    <= group_d;
    within_q   <= within_d;
    gn_q       <= gn_d;
    ws_q       <= ws_d;
    gns_q      <= gns_d;
    word_q     <= word_d;
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    res_stat_q <= res_stat_d;
    res_data_q <= res_data_d;
    m_stat_q   <= m_stat_d;
    m_data_q   <= m_data_d;
  end

  // shared divider
  r5_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // disk store
  r5_ram #(
    .WIDTH (r5_pkg::WORD_W),
    .DEPTH (2 ** (DW + OW))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready_o = (state_q == r5_pkg::ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_stat_q;
  assign m_axis_tdata_o  = m_data_q;

  // checks
  a_done_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == r5_pkg::ST_DONE && out_free) |=> m_axis_tvalid_o)
    else $error("finished query did not produce an item");

  a_unavl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == r5_pkg::STAT_UNAVL) |-> (m_axis_tdata_o == '0))
    else $error("unavailable item carries a nonzero word");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q == '1) || (32'(pcnt_q) == 32'($countones(present_q))))
    else $error("present count out of step with present bits");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == r5_pkg::ST_DIV_STRIP || state_q == r5_pkg::ST_DIV_TURN
                      || state_q == r5_pkg::ST_DIV_GROUP))
    else $error("divider finished outside a division step");

endmodule

@@ dv/raid5_word_checker.sv @@
`timescale 1ns / 1ps
// result checker for the raid-5 locate and recover block
// watches the config port and both item channels; depends on r5_pkg
module raid5_word_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [r5_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [r5_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // [19:0] target, [29:20] word_offset, [61:30] word_value, [63:62] zero
  input  logic [r5_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] command
  input  logic                          s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // [31:0] read_word
  input  logic [r5_pkg::WORD_W-1:0]     m_axis_tdata_i,
  // [0] status
  input  logic                          m_axis_tuser_i,
  output int                            pending_o,
  output int                            fails_o
);

  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned SLOT_WORDS = 1024;

  typedef struct packed {
    logic                      status;
    logic [r5_pkg::WORD_W-1:0] word;
  } read_result_t;

  read_result_t                expected_reads_q[$];
  logic [r5_pkg::WORD_W-1:0]   disk_mem [NUM_SLOTS][SLOT_WORDS];
  logic [NUM_SLOTS-1:0]        disk_loaded;
  int unsigned                 loaded_count;
  logic [r5_pkg::NDISK_W-1:0]  num_disks_r;
  logic [r5_pkg::STRIP_W-1:0]  strip_r;
  logic [r5_pkg::OFFSET_W-1:0] last_off_r;
  int                          fail_cnt;

  assign pending_o = expected_reads_q.size();
  assign fails_o   = fail_cnt;

  // map a logical block onto disk and word, then read or rebuild it
  function automatic read_result_t locate_read(logic [r5_pkg::TARGET_W-1:0] blk);
    longint unsigned n, s, strip, turn, dsk, grp, wth, wrd;
    logic [r5_pkg::WORD_W-1:0] acc;
    read_result_t res;
    n = num_disks_r;
    if (n < 2) n = 2;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    s = (strip_r == 0) ? 1 : strip_r;
    strip = blk / s;
    turn  = strip / n;
    dsk   = strip % n;
    grp   = turn / (n - 1);
    wth   = turn % (n - 1);
    wrd   = grp * n * s + ((wth >= (n - 1 - dsk)) ? s : 0) + wth * s + blk % s;
    res.status = r5_pkg::STAT_UNAVL;
    res.word   = '0;
    if (wrd <= last_off_r && wrd < SLOT_WORDS) begin
      if (disk_loaded[dsk]) begin
        res.status = r5_pkg::STAT_OK;
        res.word   = disk_mem[dsk][wrd];
      end else if (loaded_count + 1 >= n) begin
        acc = '0;
        for (int i = 0; i < n; i++)
          if (disk_loaded[i]) acc ^= disk_mem[i][wrd];
        res.status = r5_pkg::STAT_OK;
        res.word   = acc;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    read_result_t exp_r;
    logic [r5_pkg::TARGET_W-1:0] tgt;
    logic [r5_pkg::OFFSET_W-1:0] off;
    bit bad;
    if (!rst_ni) begin
      disk_loaded  <= '0;
      loaded_count <= 0;
      num_disks_r  <= r5_pkg::NDISK_W'(2);
      strip_r      <= r5_pkg::STRIP_W'(1);
      last_off_r   <= '0;
      fail_cnt     <= 0;
      expected_reads_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          r5_pkg::REG_NUM_DISKS: num_disks_r <= cfg_wdata_i[r5_pkg::NDISK_W-1:0];
          r5_pkg::REG_STRIP:     strip_r     <= cfg_wdata_i[r5_pkg::STRIP_W-1:0];
          r5_pkg::REG_LAST_OFF:  last_off_r  <= cfg_wdata_i[r5_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
      // compare result items against the oldest expectation
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_reads_q.size() == 0) begin
          $error("unexpected result item: status %0d read_word %h",
                 m_axis_tuser_i, m_axis_tdata_i);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = expected_reads_q.pop_front();
          bad = 1'b0;
          if (m_axis_tuser_i !== exp_r.status) begin
            $error("status mismatch: expected %0d actual %0d", exp_r.status, m_axis_tuser_i);
            bad = 1'b1;
          end
          if (m_axis_tdata_i !== exp_r.word) begin
            $error("read_word mismatch: expected %h actual %h", exp_r.word, m_axis_tdata_i);
            bad = 1'b1;
          end
          if (bad) fail_cnt <= fail_cnt + 1;
        end
      end
      // input items: loads update the store, queries queue a result
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        tgt = s_axis_tdata_i[r5_pkg::TARGET_W-1:0];
        off = s_axis_tdata_i[r5_pkg::TARGET_W +: r5_pkg::OFFSET_W];
        if (s_axis_tuser_i == r5_pkg::CMD_LOAD) begin
          if (tgt < NUM_SLOTS) begin
            disk_mem[tgt][off] =
              s_axis_tdata_i[r5_pkg::TARGET_W+r5_pkg::OFFSET_W +: r5_pkg::WORD_W];
            if (!disk_loaded[tgt]) begin
              disk_loaded[tgt] <= 1'b1;
              if (loaded_count < 31) loaded_count <= loaded_count + 1;
            end
          end
        end else begin
          expected_reads_q.push_back(locate_read(tgt));
        end
      end
    end
  end

endmodule

@@ dv/raid5_block_locate_and_recover_test.sv @@
`timescale 1ns / 1ps
// top of the raid-5 locate and recover testbench: clock, reset, stimulus, verdict
// depends on r5_pkg, the block and raid5_word_checker
module raid5_block_locate_and_recover_test;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 150;
  localparam int NUM_SLOTS  = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [r5_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [r5_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                          s_tvalid  = 1'b0;
  logic [r5_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          m_tready  = 1'b0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [r5_pkg::WORD_W-1:0]     m_tdata;
  logic                          m_tuser;
  int                            reads_pending;
  int                            fail_total;

  // stimulus bookkeeping: which disks are loaded and how far each is filled
  logic [NUM_SLOTS-1:0] disk_on = '0;
  int  filled_hi [NUM_SLOTS];
  int  cur_last_off;
  int  eff_disks;
  int  eff_strip;
  bit  no_idle   = 1'b0;
  bit  hold_req  = 1'b0;
  int  idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  raid5_block_locate_and_recover dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  raid5_word_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser),
    .pending_o(reads_pending), .fails_o(fail_total)
  );

  // watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, one long hold on request
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (500) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic cmd, logic [r5_pkg::TARGET_W-1:0] tgt,
                           logic [r5_pkg::OFFSET_W-1:0] off,
                           logic [r5_pkg::WORD_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, val, off, tgt};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // stop offering and wait until every result is back and the block settles
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (reads_pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [r5_pkg::CFG_IDX_W-1:0] idx,
                           logic [r5_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(int nd, int sb, int lo);
    write_reg(r5_pkg::REG_NUM_DISKS, r5_pkg::CFG_DATA_W'(nd));
    write_reg(r5_pkg::REG_STRIP, r5_pkg::CFG_DATA_W'(sb));
    write_reg(r5_pkg::REG_LAST_OFF, r5_pkg::CFG_DATA_W'(lo));
    cfg_we <= 1'b0;
    eff_disks = (nd < 2) ? 2 : (nd > NUM_SLOTS) ? NUM_SLOTS : nd;
    eff_strip = (sb == 0) ? 1 : sb;
    cur_last_off = lo;
  endtask

  // write every word up to hi on a disk so no query reads an unwritten word
  task automatic fill_disk(int d, int hi);
    for (int off = filled_hi[d] + 1; off <= hi; off++)
      send_item(r5_pkg::CMD_LOAD, r5_pkg::TARGET_W'(d), r5_pkg::OFFSET_W'(off), $urandom());
    if (hi > filled_hi[d]) filled_hi[d] = hi;
    disk_on[d] = 1'b1;
  endtask

  task automatic fill_loaded();
    for (int d = 0; d < NUM_SLOTS; d++)
      if (disk_on[d]) fill_disk(d, cur_last_off);
  endtask

  function automatic logic [r5_pkg::TARGET_W-1:0] pick_block();
    int r;
    longint span;
    r = $urandom_range(0, 99);
    span = longint'(eff_disks) * eff_strip * (cur_last_off + 1) * 2;
    if (span > 1048575) span = 1048575;
    if (r < 50) return r5_pkg::TARGET_W'($urandom_range(0, int'(span)));
    if (r < 70) return r5_pkg::TARGET_W'($urandom_range(0, 15));
    return r5_pkg::TARGET_W'($urandom());
  endfunction

  function automatic int pick_disks();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 16;
      4: return 17;
      5: return 31;
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic int pick_strip();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 1024;
      3: return 2047;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    int r;
    int d;
    for (int i = 0; i < NUM_SLOTS; i++) filled_hi[i] = -1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: nothing loaded, widest offset range, every query unavailable
    set_config(2, 1, 1023);
    send_item(r5_pkg::CMD_QUERY, '0, '0, '0);
    send_item(r5_pkg::CMD_QUERY, '1, '1, '1);
    send_item(r5_pkg::CMD_QUERY, r5_pkg::TARGET_W'(1046529), '0, '0);
    // loads to a disk index past the array are dropped
    send_item(r5_pkg::CMD_LOAD, r5_pkg::TARGET_W'(16), '1, '1);
    send_item(r5_pkg::CMD_LOAD, '1, '1, '1);
    send_item(r5_pkg::CMD_QUERY, r5_pkg::TARGET_W'(1), '0, '0);
    drain();

    // directed: one disk loaded, too many missing, then rebuild from two
    set_config(3, 2, 3);
    send_item(r5_pkg::CMD_LOAD, '0, '0, '0);
    send_item(r5_pkg::CMD_LOAD, '0, r5_pkg::OFFSET_W'(1), '1);
    filled_hi[0] = 1;
    fill_disk(0, 3);
    for (int t = 0; t < 6; t++) send_item(r5_pkg::CMD_QUERY, r5_pkg::TARGET_W'(t), '0, '0);
    fill_disk(1, 3);
    for (int t = 0; t < 12; t++) send_item(r5_pkg::CMD_QUERY, r5_pkg::TARGET_W'(t), '0, '0);
    // reload of a loaded disk overwrites
    send_item(r5_pkg::CMD_LOAD, '0, '0, 32'hA5A5_5A5A);
    send_item(r5_pkg::CMD_QUERY, '0, '0, '0);
    send_item(r5_pkg::CMD_QUERY, r5_pkg::TARGET_W'(1), '0, '0);
    drain();

    // random phases
    for (int ph = 0; ph < 13; ph++) begin
      no_idle = (ph == 2 || ph == 9);
      set_config(pick_disks(), pick_strip(),
                 ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 31));
      fill_loaded();
      repeat ($urandom_range(0, 2)) begin
        d = $urandom_range(0, NUM_SLOTS - 1);
        if (!disk_on[d]) fill_disk(d, cur_last_off);
      end
      for (int k = 0; k < 45; k++) begin
        if (ph == 4 && k == 5) hold_req = 1'b1;
        if (ph == 6 && k == 30) drain();
        r = $urandom_range(0, 99);
        if (r < 65 || disk_on == '0) begin
          send_item(r5_pkg::CMD_QUERY, pick_block(), r5_pkg::OFFSET_W'($urandom()),
                    $urandom());
        end else if (r < 85) begin
          do d = $urandom_range(0, NUM_SLOTS - 1); while (!disk_on[d]);
          send_item(r5_pkg::CMD_LOAD, r5_pkg::TARGET_W'(d), r5_pkg::OFFSET_W'($urandom()),
                    $urandom());
        end else begin
          send_item(r5_pkg::CMD_LOAD, r5_pkg::TARGET_W'($urandom_range(16, 1048575)),
                    r5_pkg::OFFSET_W'($urandom()), $urandom());
        end
      end
      drain();
    end

    if (fail_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
